FILE: rtl/b64d_pkg.sv
// b64d_pkg: shared types, constants and the symbol lookup for the base64 stream decoder
// no dependencies; imported by every rtl module
`timescale 1ns / 1ps

package b64d_pkg;

    localparam logic [7:0]  PAD_CHAR     = 8'h3D;   // '='
    localparam logic [5:0]  SYM_PLUS     = 6'd62;
    localparam logic [5:0]  SYM_SLASH    = 6'd63;
    localparam logic [15:0] CAP_RESET    = 16'hFFFF;
    localparam int          QDEPTH       = 4;
    localparam int          QPTR_W       = 2;
    localparam int          QCNT_W       = 3;

    // decoded alphabet symbol
    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } sym_t;

    // work handed from front to back: up to three data bytes, then an optional summary
    typedef struct packed {
        logic [1:0]  nbytes;
        logic [23:0] data;
        logic        summary;
        logic        status;
        logic [15:0] count;
    } job_t;

    // queue occupancy flags
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic sym_t sym_decode(input logic [7:0] c);
        sym_t s;
        s.ok  = 1'b1;
        s.val = 6'd0;
        if (c >= 8'd65 && c <= 8'd90) begin
            s.val = 6'(c - 8'd65);
        end else if (c >= 8'd97 && c <= 8'd122) begin
            s.val = 6'(c - 8'd71);
        end else if (c >= 8'd48 && c <= 8'd57) begin
            s.val = 6'(c + 8'd4);
        end else if (c == 8'd43) begin
            s.val = SYM_PLUS;
        end else if (c == 8'd47) begin
            s.val = SYM_SLASH;
        end else begin
            s.ok = 1'b0;
        end
        return s;
    endfunction

endpackage

FILE: rtl/b64d_intf.sv
// b64d_intf: valid/ready channel interfaces for characters, decoded words and configuration
// no dependencies
`timescale 1ns / 1ps

interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] sym_char;
    logic       end_of_input;

    modport source (output valid, output sym_char, output end_of_input, input ready);
    modport sink   (input valid, input sym_char, input end_of_input, output ready);
endinterface

interface b64d_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        run_last;
    logic        msg_done;
    logic        status;
    logic [15:0] byte_count;

    modport source (output valid, output out_byte, output byte_valid, output run_last,
                    output msg_done, output status, output byte_count, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                    input msg_done, input status, input byte_count, output ready);
endinterface

interface b64d_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/b64d_front.sv
// b64d_front: takes characters, tracks the decode state and capacity, queues output jobs
// depends on b64d_pkg and b64d_intf
`timescale 1ns / 1ps

module b64d_front #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    b64d_char_if.sink           char_ch,
    b64d_cfg_if.sink            cfg_ch,
    input  b64d_pkg::q_stat_t   q_stat,
    output logic                push,
    output b64d_pkg::job_t      job
);
    import b64d_pkg::*;

    localparam int CMP_W = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;
    localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'((65'd1 << COUNT_WIDTH) - 65'd1);

    logic [15:0]            cap_reg;
    logic [17:0]            acc_reg,  acc_next;
    logic [1:0]             cnt_reg,  cnt_next;
    logic                   pad_reg,  pad_next;
    logic                   ovf_reg,  ovf_next;
    logic [COUNT_WIDTH-1:0] bw_reg,   bw_next;

    logic                   accept;
    sym_t                   sym;
    logic                   take;
    logic                   grp;
    logic [17:0]            acc_upd;
    logic [1:0]             cnt_upd;
    logic [1:0]             n_emit;
    logic [23:0]            data;
    logic [CMP_W-1:0]       cap_ext;
    logic [CMP_W-1:0]       eff_cap;
    logic [CMP_W-1:0]       sum;
    logic                   fits;
    logic                   emit_ok;
    logic                   ovf_upd;
    logic [COUNT_WIDTH-1:0] bw_upd;
    logic [CMP_W-1:0]       bw_upd_ext;

    assign char_ch.ready = !q_stat.full;
    assign cfg_ch.ready  = 1'b1;
    assign accept        = char_ch.valid && char_ch.ready;

    always_comb
    begin
        sym     = sym_decode(char_ch.sym_char);
        take    = !pad_reg && (char_ch.sym_char != PAD_CHAR) && sym.ok;
        grp     = take && (cnt_reg == 2'd3);
        acc_upd = grp ? 18'd0 : (take ? {acc_reg[11:0], sym.val} : acc_reg);
        cnt_upd = grp ? 2'd0 : (take ? cnt_reg + 2'd1 : cnt_reg);

        // full group first; a leftover of two or three symbols flushes at end of message
        if (grp) begin
            n_emit = 2'd3;
        end else if (char_ch.end_of_input && cnt_upd == 2'd3) begin
            n_emit = 2'd2;
        end else if (char_ch.end_of_input && cnt_upd == 2'd2) begin
            n_emit = 2'd1;
        end else begin
            n_emit = 2'd0;
        end

        if (grp) begin
            data = {acc_reg, sym.val};
        end else if (cnt_upd == 2'd3) begin
            data = {acc_upd[17:2], 8'h00};
        end else begin
            data = {acc_upd[11:4], 16'h0000};
        end

        cap_ext    = CMP_W'(cap_reg);
        eff_cap    = (cap_ext < CNT_MAX) ? cap_ext : CNT_MAX;
        sum        = CMP_W'(bw_reg) + CMP_W'(n_emit);
        fits       = (sum <= eff_cap);
        emit_ok    = (n_emit != 2'd0) && !ovf_reg && fits;
        ovf_upd    = ovf_reg || ((n_emit != 2'd0) && !fits);
        bw_upd     = emit_ok ? sum[COUNT_WIDTH-1:0] : bw_reg;
        bw_upd_ext = CMP_W'(bw_upd);
    end

    always_comb
    begin
        job.nbytes  = emit_ok ? n_emit : 2'd0;
        job.data    = data;
        job.summary = char_ch.end_of_input;
        job.status  = ovf_upd;
        job.count   = ovf_upd ? 16'd0 : bw_upd_ext[15:0];
        push        = accept && (emit_ok || char_ch.end_of_input);
    end

    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        pad_next = pad_reg;
        ovf_next = ovf_reg;
        bw_next  = bw_reg;
        if (accept) begin
            if (char_ch.end_of_input) begin
                acc_next = 18'd0;
                cnt_next = 2'd0;
                pad_next = 1'b0;
                ovf_next = 1'b0;
                bw_next  = '0;
            end else begin
                acc_next = acc_upd;
                cnt_next = cnt_upd;
                pad_next = pad_reg || (char_ch.sym_char == PAD_CHAR);
                ovf_next = ovf_upd;
                bw_next  = bw_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cap_reg <= CAP_RESET;
            acc_reg <= 18'd0;
            cnt_reg <= 2'd0;
            pad_reg <= 1'b0;
            ovf_reg <= 1'b0;
            bw_reg  <= '0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                cap_reg <= cfg_ch.data;
            end
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            pad_reg <= pad_next;
            ovf_reg <= ovf_next;
            bw_reg  <= bw_next;
        end
    end

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && char_ch.end_of_input |=>
            (cnt_reg == 2'd0) && !pad_reg && !ovf_reg && (bw_reg == '0))
        else $error("message state not cleared after end of input");

    a_emit_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        push && (job.nbytes != 2'd0) |-> !ovf_reg)
        else $error("bytes queued after overflow");

endmodule

FILE: rtl/b64d_queue.sv
// b64d_queue: short job queue between the character front and the output back
// depends on b64d_pkg
`timescale 1ns / 1ps

module b64d_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  b64d_pkg::job_t      push_job,
    input  logic                pop,
    output b64d_pkg::job_t      head_job,
    output b64d_pkg::q_stat_t   q_stat
);
    import b64d_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;

    assign q_stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head_job     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !push)
        else $error("job pushed into a full queue");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |-> !pop)
        else $error("job popped from an empty queue");

endmodule

FILE: rtl/b64d_back.sv
// b64d_back: walks each queued job and issues its words through an output register
// depends on b64d_pkg and b64d_intf
`timescale 1ns / 1ps

module b64d_back (
    input  logic                clk,
    input  logic                rst_n,
    input  b64d_pkg::job_t      head_job,
    input  b64d_pkg::q_stat_t   q_stat,
    output logic                pop,
    b64d_byte_if.source         byte_ch
);
    import b64d_pkg::*;

    logic        ov_reg,   ov_next;
    logic [1:0]  idx_reg,  idx_next;
    logic [7:0]  byte_reg;
    logic        bval_reg;
    logic        last_reg;
    logic        done_reg;
    logic        stat_reg;
    logic [15:0] cnt_reg;

    logic        load;
    logic [2:0]  total;
    logic        is_last;
    logic        is_data;
    logic [7:0]  sel_byte;

    always_comb
    begin
        load    = !q_stat.empty && (!ov_reg || byte_ch.ready);
        total   = {1'b0, head_job.nbytes} + {2'b00, head_job.summary};
        is_last = ({1'b0, idx_reg} + 3'd1) == total;
        is_data = idx_reg < head_job.nbytes;
        case (idx_reg)
            2'd0:    sel_byte = head_job.data[23:16];
            2'd1:    sel_byte = head_job.data[15:8];
            default: sel_byte = head_job.data[7:0];
        endcase
        pop      = load && is_last;
        idx_next = load ? (is_last ? 2'd0 : idx_reg + 2'd1) : idx_reg;
        ov_next  = load ? 1'b1 : (byte_ch.ready ? 1'b0 : ov_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ov_reg  <= 1'b0;
            idx_reg <= 2'd0;
        end else begin
            ov_reg  <= ov_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            byte_reg <= is_data ? sel_byte : 8'h00;
            bval_reg <= is_data;
            last_reg <= is_last;
            done_reg <= !is_data;
            stat_reg <= is_data ? 1'b0 : head_job.status;
            cnt_reg  <= is_data ? 16'd0 : head_job.count;
        end
    end

    assign byte_ch.valid      = ov_reg;
    assign byte_ch.out_byte   = byte_reg;
    assign byte_ch.byte_valid = bval_reg;
    assign byte_ch.run_last   = last_reg;
    assign byte_ch.msg_done   = done_reg;
    assign byte_ch.status     = stat_reg;
    assign byte_ch.byte_count = cnt_reg;

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && done_reg |-> last_reg && !bval_reg)
        else $error("summary word not marked as last");

    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        !q_stat.empty |-> ({1'b0, idx_reg} < total))
        else $error("word index beyond the current job");

endmodule

FILE: rtl/base64_stream_decoder_top.sv
// base64_stream_decoder_top: top level of the base64 stream decoder
// depends on b64d_pkg, b64d_intf, b64d_front, b64d_queue, b64d_back
`timescale 1ns / 1ps
//
// usage
//  char_ch : one encoded character word per handshake, end_of_input marks the last
//            character of a message; characters outside the alphabet are skipped and
//            an '=' ends decoding for the rest of the message
//  byte_ch : decoded words; data bytes carry byte_valid, the word closing a message
//            carries msg_done with status (overflow) and byte_count; run_last flags the
//            final word caused by one character
//  cfg_ch  : write of out_capacity, the byte limit per message; write it only while idle
//
// timing
//  a character is taken every cycle while the job queue has room; its first word goes
//  into the job queue and then into the output register, from which byte_ch presents it.
//  the back end issues one word per cycle while byte_ch is ready, so a character ending
//  a full group plus the message yields four output words; a typical stream (three bytes
//  per four characters) runs at one character per cycle while byte_ch is ready
//  the four-entry job queue and the output register decouple the two sides: a stalled
//  receiver holds the current word, the queue absorbs further characters, and char_ch
//  ready drops only when the queue is full
//  reset clears all message state, empties the queue and sets out_capacity to 65535
//

module base64_stream_decoder_top #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    b64d_char_if.sink   char_ch,
    b64d_byte_if.source byte_ch,
    b64d_cfg_if.sink    cfg_ch
);
    import b64d_pkg::*;

    // front to queue
    logic    push;
    job_t    push_job;
    // queue to back
    logic    pop;
    job_t    head_job;
    q_stat_t q_stat;

    // decode state, capacity check and job building
    b64d_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_ch (char_ch),
        .cfg_ch  (cfg_ch),
        .q_stat  (q_stat),
        .push    (push),
        .job     (push_job)
    );

    // short job queue so each side stalls on its own
    b64d_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_stat   (q_stat)
    );

    // one output word per cycle from the queued jobs while byte_ch is ready
    b64d_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .q_stat   (q_stat),
        .pop      (pop),
        .byte_ch  (byte_ch)
    );

endmodule
